>>> src/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg: shared types and constants of the dirty rectangle coalescer
// Request and response payloads, command, status and register codes.
// ----------------------------------------------------------------------------
package drc_pkg;

   // Defaults of the top level parameters
   localparam int MAX_REGIONS_DEF = 16;
   localparam int COORD_BITS_DEF  = 13;

   // Fixed field widths of the ports
   localparam int CMD_W    = 2;
   localparam int EDGE_W   = 16;
   localparam int STATUS_W = 3;
   localparam int OUT_W    = 13;
   localparam int CSR_W    = 13;
   localparam int CSR_IDX_W = 1;

   // Commands
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ    = 3'd4;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;
   localparam logic [CSR_W-1:0]     SCREEN_WIDTH_RST  = 13'd640;
   localparam logic [CSR_W-1:0]     SCREEN_HEIGHT_RST = 13'd480;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [EDGE_W-1:0] rect_left;
      logic signed [EDGE_W-1:0] rect_top;
      logic signed [EDGE_W-1:0] rect_right;
      logic signed [EDGE_W-1:0] rect_bottom;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OUT_W-1:0]    out_x;
      logic [OUT_W-1:0]    out_y;
      logic [OUT_W-1:0]    out_w;
      logic [OUT_W-1:0]    out_h;
      logic                last;
      logic                overflowed;
   } rsp_type;

endpackage

>>> src/drc_ram.sv
// ----------------------------------------------------------------------------
// drc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data that holds while
// no read is issued.
// ----------------------------------------------------------------------------
module drc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/dirty_rect_coalescer.sv
// ----------------------------------------------------------------------------
// dirty_rect_coalescer: ordered table of dirty screen rectangles
// Sequence: clear and an empty read go straight to the response; a read gives one response per entry;
//   an unknown command is dropped with no response; an add clamps, scans the table in P passes
//   (1 to N+1, N entries), compacts when entries merged and appends, or ends on a full table or a clamped-empty box.
// Throughput: one request at a time; the next one is taken while a response waits.
// Reset: empty table, overflow flag clear, screen 640x480; the RAM is not cleared.
// ----------------------------------------------------------------------------
//
// The rectangle table lives in one simple dual-port RAM, one word per entry
// holding x, y, w and h. An add clamps the rectangle, then scans the table in
// passes: each entry that touches the growing box is merged and marked in a
// removal mask. Merging is monotone, so repeating passes until one pass merges
// nothing reaches the same set of merged entries as restarting after each
// merge. A compaction pass then copies the surviving entries down in order
// (write index never passes the read index, so no forwarding is needed) and
// the box is appended at the end.
module dirty_rect_coalescer #(
   parameter int MAX_REGIONS = drc_pkg::MAX_REGIONS_DEF,
   parameter int COORD_BITS  = drc_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  drc_pkg::req_type               req_data,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output drc_pkg::rsp_type               rsp_data,
   // configuration port
   input  logic                           csr_we,
   input  logic [drc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [drc_pkg::CSR_W-1:0]      csr_wdata
);

   import drc_pkg::*;

   localparam int IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
   localparam int WORD_W = 4 * COORD_BITS;
   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
   localparam logic [CNT_W-1:0]      CNT_FULL  = CNT_W'(MAX_REGIONS);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_CLAMP    = 8'b0000_0010,
      S_SCAN     = 8'b0000_0100,
      S_COMPACT  = 8'b0000_1000,
      S_FINISH   = 8'b0001_0000,
      S_EMIT     = 8'b0010_0000,
      S_RD_ISSUE = 8'b0100_0000,
      S_RD_EMIT  = 8'b1000_0000
   } state_type;

   // Clamp a signed edge to [0, hi].
   function automatic logic [COORD_BITS-1:0] clamp_edge(
      input logic signed [EDGE_W-1:0] v,
      input logic [COORD_BITS-1:0]    hi
   );
      logic signed [EDGE_W:0] vv;
      logic signed [EDGE_W:0] hh;
      vv = (EDGE_W + 1)'(v);
      hh = $signed((EDGE_W + 1)'(hi));
      if (vv < 0) begin
         return '0;
      end else if (vv > hh) begin
         return hi;
      end else begin
         return COORD_BITS'(vv);
      end
   endfunction

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [CSR_W-1:0]       scr_w_ff, scr_w_in;
   logic [CSR_W-1:0]       scr_h_ff, scr_h_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [COORD_BITS-1:0]  bl_ff, bl_in;     // box left
   logic [COORD_BITS-1:0]  bt_ff, bt_in;     // box top
   logic [COORD_BITS-1:0]  br_ff, br_in;     // box right, exclusive
   logic [COORD_BITS-1:0]  bb_ff, bb_in;     // box bottom, exclusive
   logic [MAX_REGIONS-1:0] removed_ff, removed_in;
   logic [CNT_W-1:0]       rm_cnt_ff, rm_cnt_in;
   logic                   merged_ff, merged_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]       wr_idx_ff, wr_idx_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pidx_ff, pidx_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // ------------------------------------------------------------------
   // Table RAM
   // ------------------------------------------------------------------
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [WORD_W-1:0] ram_rd_data;

   drc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Datapath helpers
   // ------------------------------------------------------------------
   logic                  req_acc;
   logic                  out_free;
   logic [COORD_BITS-1:0] sw_lim, sh_lim;
   logic [COORD_BITS-1:0] cl_l, cl_t, cl_r, cl_b;
   logic                  cl_empty;
   logic [COORD_BITS-1:0] cx, cy, cw, ch;
   logic [COORD_BITS:0]   c_right, c_bottom;
   logic [COORD_BITS-1:0] c_right_t, c_bottom_t;
   logic                  apart, hit, issue;

   assign req_acc  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Saturate the screen size to the coordinate range.
   assign sw_lim = ((COORD_BITS + CSR_W)'(scr_w_ff) > (COORD_BITS + CSR_W)'(COORD_MAX)) ?
                   COORD_MAX : COORD_BITS'(scr_w_ff);
   assign sh_lim = ((COORD_BITS + CSR_W)'(scr_h_ff) > (COORD_BITS + CSR_W)'(COORD_MAX)) ?
                   COORD_MAX : COORD_BITS'(scr_h_ff);

   assign cl_l = clamp_edge(req_ff.rect_left, sw_lim);
   assign cl_t = clamp_edge(req_ff.rect_top, sh_lim);
   assign cl_r = clamp_edge(req_ff.rect_right, sw_lim);
   assign cl_b = clamp_edge(req_ff.rect_bottom, sh_lim);
   assign cl_empty = (cl_l >= cl_r) || (cl_t >= cl_b);

   // Unpack the entry held in the RAM's registered read data.
   assign cx = ram_rd_data[4*COORD_BITS-1:3*COORD_BITS];
   assign cy = ram_rd_data[3*COORD_BITS-1:2*COORD_BITS];
   assign cw = ram_rd_data[2*COORD_BITS-1:COORD_BITS];
   assign ch = ram_rd_data[COORD_BITS-1:0];
   assign c_right    = {1'b0, cx} + {1'b0, cw};
   assign c_bottom   = {1'b0, cy} + {1'b0, ch};
   assign c_right_t  = COORD_BITS'(c_right);
   assign c_bottom_t = COORD_BITS'(c_bottom);

   // Separated only when an edge lies strictly before the opposite edge.
   assign apart = ({1'b0, br_ff} < {1'b0, cx}) || (c_right < {1'b0, bl_ff}) ||
                  ({1'b0, bb_ff} < {1'b0, cy}) || (c_bottom < {1'b0, bt_ff});
   assign hit   = pend_ff && !removed_ff[pidx_ff] && !apart;
   assign issue = (rd_idx_ff < count_ff);

   // ------------------------------------------------------------------
   // Control
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      scr_w_in     = scr_w_ff;
      scr_h_in     = scr_h_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      bl_in        = bl_ff;
      bt_in        = bt_ff;
      br_in        = br_ff;
      bb_in        = bb_ff;
      removed_in   = removed_ff;
      rm_cnt_in    = rm_cnt_ff;
      merged_in    = merged_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      res_in       = res_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_idx_ff[IDX_W-1:0];
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;

      // Configuration writes, taken in any state.
      if (csr_we) begin
         case (csr_index)
            REG_SCREEN_WIDTH: begin
               scr_w_in = csr_wdata;
            end
            REG_SCREEN_HEIGHT: begin
               scr_h_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               req_in = req_data;
               res_in = '0;
               res_in.last = 1'b1;
               case (req_data.command)
                  CMD_ADD: begin
                     state_in = S_CLAMP;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                     res_in.status = ST_CLEARED;
                     state_in = S_EMIT;
                  end
                  CMD_READ: begin
                     rd_idx_in = '0;
                     if (count_ff == '0) begin
                        res_in.status = ST_READ;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_RD_ISSUE;
                     end
                  end
                  default: begin
                     // unknown command: drop it, no response
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_CLAMP: begin
            if (cl_empty) begin
               res_in.status = ST_EMPTY;
               state_in = S_EMIT;
            end else begin
               bl_in      = cl_l;
               bt_in      = cl_t;
               br_in      = cl_r;
               bb_in      = cl_b;
               removed_in = '0;
               rm_cnt_in  = '0;
               merged_in  = 1'b0;
               rd_idx_in  = '0;
               state_in   = S_SCAN;
            end
         end

         S_SCAN: begin
            if (issue) begin
               ram_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
               pidx_in   = rd_idx_ff[IDX_W-1:0];
            end
            if (hit) begin
               // absorb the entry into the box
               bl_in = (cx < bl_ff) ? cx : bl_ff;
               bt_in = (cy < bt_ff) ? cy : bt_ff;
               br_in = (c_right_t > br_ff) ? c_right_t : br_ff;
               bb_in = (c_bottom_t > bb_ff) ? c_bottom_t : bb_ff;
               removed_in[pidx_ff] = 1'b1;
               rm_cnt_in = rm_cnt_ff + 1'b1;
               merged_in = 1'b1;
            end
            if (!issue && !pend_ff) begin
               if (merged_ff) begin
                  // box grew: run another pass
                  rd_idx_in = '0;
                  merged_in = 1'b0;
               end else if (rm_cnt_ff != '0) begin
                  rd_idx_in = '0;
                  wr_idx_in = '0;
                  state_in  = S_COMPACT;
               end else if (count_ff == CNT_FULL) begin
                  ovf_in = 1'b1;
                  res_in.status = ST_FULL;
                  res_in.out_x  = OUT_W'(bl_ff);
                  res_in.out_y  = OUT_W'(bt_ff);
                  res_in.out_w  = OUT_W'(br_ff - bl_ff);
                  res_in.out_h  = OUT_W'(bb_ff - bt_ff);
                  state_in = S_EMIT;
               end else begin
                  wr_idx_in = count_ff;
                  state_in  = S_FINISH;
               end
            end
         end

         S_COMPACT: begin
            if (issue) begin
               ram_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
               pidx_in   = rd_idx_ff[IDX_W-1:0];
            end
            if (pend_ff && !removed_ff[pidx_ff]) begin
               // copy the survivor down
               ram_wr_en = 1'b1;
               wr_idx_in = wr_idx_ff + 1'b1;
            end
            if (!issue && !pend_ff) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // append the box
            ram_wr_en   = 1'b1;
            ram_wr_data = {bl_ff, bt_ff, br_ff - bl_ff, bb_ff - bt_ff};
            count_in    = wr_idx_ff + 1'b1;
            res_in.status = ST_STORED;
            res_in.out_x  = OUT_W'(bl_ff);
            res_in.out_y  = OUT_W'(bt_ff);
            res_in.out_w  = OUT_W'(br_ff - bl_ff);
            res_in.out_h  = OUT_W'(bb_ff - bt_ff);
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_data_in.overflowed = ovf_ff;
               state_in = S_IDLE;
            end
         end

         S_RD_ISSUE: begin
            ram_rd_en = 1'b1;
            state_in  = S_RD_EMIT;
         end

         S_RD_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status     = ST_READ;
               rsp_data_in.out_x      = OUT_W'(cx);
               rsp_data_in.out_y      = OUT_W'(cy);
               rsp_data_in.out_w      = OUT_W'(cw);
               rsp_data_in.out_h      = OUT_W'(ch);
               rsp_data_in.last       = (CNT_W'(rd_idx_ff + 1'b1) == count_ff);
               rsp_data_in.overflowed = ovf_ff;
               rd_idx_in = rd_idx_ff + 1'b1;
               state_in  = (CNT_W'(rd_idx_ff + 1'b1) == count_ff) ? S_IDLE : S_RD_ISSUE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scr_w_ff     <= SCREEN_WIDTH_RST;
         scr_h_ff     <= SCREEN_HEIGHT_RST;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         removed_ff   <= '0;
         rm_cnt_ff    <= '0;
         merged_ff    <= 1'b0;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scr_w_ff     <= scr_w_in;
         scr_h_ff     <= scr_h_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         removed_ff   <= removed_in;
         rm_cnt_ff    <= rm_cnt_in;
         merged_ff    <= merged_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      bl_ff       <= bl_in;
      bt_ff       <= bt_in;
      br_ff       <= br_in;
      bb_ff       <= bb_in;
      pidx_ff     <= pidx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // Compaction writes never overtake the reads they copy from.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMPACT) |-> (wr_idx_ff <= rd_idx_ff))
      else $error("compaction write index passed read index");

   // The removal mask and its counter agree during a scan.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> ($countones(removed_ff) == 32'(rm_cnt_ff)))
      else $error("removal mask and counter disagree");

   // An append always has a free slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> (wr_idx_ff < CNT_FULL))
      else $error("append into a full table");

   // A clear empties the table and drops the overflow flag.
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_data.command == CMD_CLEAR)) |=> ((count_ff == '0) && !ovf_ff))
      else $error("clear did not empty the table");
`endif

endmodule

>>> tb/tb_dirty_rect_coalescer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dirty_rect_coalescer: self-checking bench for the dirty rectangle table
// Runs directed and random add, clear and read requests over several screen
// sizes. Responses are checked in order against a cycle-free table predictor.
// ----------------------------------------------------------------------------
module tb_dirty_rect_coalescer;
   import drc_pkg::*;

   // Command code that the block has to ignore
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int TBL_DEPTH   = MAX_REGIONS_DEF;
   localparam int COORD_MAX   = (1 << COORD_BITS_DEF) - 1;
   // Wait after draining, sized to cover the worst add with its passes and compaction
   localparam int TAIL_CYCLES = 400;
   localparam int DRAIN_LIMIT = 200000;
   localparam int HOLD_LEN    = 300;

   logic    clock = 1'b1;
   logic    reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;

   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   dirty_rect_coalescer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Requests waiting to be offered, responses waiting to arrive
   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      mismatch_count = 0;

   // Flow shaping: steady turns off all idling, hold_armed starts one long
   // response hold-off that its own process counts down
   bit   steady     = 1'b0;
   bit   hold_armed = 1'b0;
   int   hold_cycles = 0;
   logic hold_active;

   assign hold_active = hold_armed && (hold_cycles < HOLD_LEN);

   always @(posedge clock) begin
      if (hold_active) begin
         hold_cycles <= hold_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // Table predictor: own copy of the rectangle table and screen size
   // --------------------------------------------------------------------------
   int tbl_x[TBL_DEPTH];
   int tbl_y[TBL_DEPTH];
   int tbl_w[TBL_DEPTH];
   int tbl_h[TBL_DEPTH];
   int tbl_count    = 0;
   bit tbl_overflow = 1'b0;
   int scr_width    = SCREEN_WIDTH_RST;
   int scr_height   = SCREEN_HEIGHT_RST;

   function automatic void expect_rsp(logic [STATUS_W-1:0] st, int x, int y, int w, int h,
                                      bit last);
      rsp_type e;
      e.status     = st;
      e.out_x      = OUT_W'(x);
      e.out_y      = OUT_W'(y);
      e.out_w      = OUT_W'(w);
      e.out_h      = OUT_W'(h);
      e.last       = last;
      e.overflowed = tbl_overflow;
      expected_rsps = {expected_rsps, e};
   endfunction

   function automatic int clamp_edge(int v, int hi);
      return (v < 0) ? 0 : ((v > hi) ? hi : v);
   endfunction

   function automatic void predict_add(req_type r);
      int  sw, sh, l, t, rt, b;
      int  mx, my, mw, mh, ex, ey, i, j;
      bit  apart;
      sw = (scr_width < COORD_MAX) ? scr_width : COORD_MAX;
      sh = (scr_height < COORD_MAX) ? scr_height : COORD_MAX;
      l  = clamp_edge(int'($signed(r.rect_left)), sw);
      t  = clamp_edge(int'($signed(r.rect_top)), sh);
      rt = clamp_edge(int'($signed(r.rect_right)), sw);
      b  = clamp_edge(int'($signed(r.rect_bottom)), sh);
      if (l >= rt || t >= b) begin
         expect_rsp(ST_EMPTY, 0, 0, 0, 0, 1'b1);
         return;
      end
      mx = l;
      my = t;
      mw = rt - l;
      mh = b - t;
      // Absorb touching entries; restart from the head after every merge
      i = 0;
      while (i < tbl_count) begin
         apart = (mx + mw < tbl_x[i]) || (tbl_x[i] + tbl_w[i] < mx) ||
                 (my + mh < tbl_y[i]) || (tbl_y[i] + tbl_h[i] < my);
         if (apart) begin
            i++;
         end else begin
            ex = (mx + mw > tbl_x[i] + tbl_w[i]) ? mx + mw : tbl_x[i] + tbl_w[i];
            ey = (my + mh > tbl_y[i] + tbl_h[i]) ? my + mh : tbl_y[i] + tbl_h[i];
            mx = (mx < tbl_x[i]) ? mx : tbl_x[i];
            my = (my < tbl_y[i]) ? my : tbl_y[i];
            mw = ex - mx;
            mh = ey - my;
            for (j = i; j + 1 < tbl_count; j++) begin
               tbl_x[j] = tbl_x[j + 1];
               tbl_y[j] = tbl_y[j + 1];
               tbl_w[j] = tbl_w[j + 1];
               tbl_h[j] = tbl_h[j + 1];
            end
            tbl_count--;
            i = 0;
         end
      end
      if (tbl_count >= TBL_DEPTH) begin
         tbl_overflow = 1'b1;
         expect_rsp(ST_FULL, mx, my, mw, mh, 1'b1);
         return;
      end
      tbl_x[tbl_count] = mx;
      tbl_y[tbl_count] = my;
      tbl_w[tbl_count] = mw;
      tbl_h[tbl_count] = mh;
      tbl_count++;
      expect_rsp(ST_STORED, mx, my, mw, mh, 1'b1);
   endfunction

   function automatic void predict_request(req_type r);
      int k;
      case (r.command)
         CMD_ADD: begin
            predict_add(r);
         end
         CMD_CLEAR: begin
            tbl_count    = 0;
            tbl_overflow = 1'b0;
            expect_rsp(ST_CLEARED, 0, 0, 0, 0, 1'b1);
         end
         CMD_READ: begin
            if (tbl_count == 0) begin
               expect_rsp(ST_READ, 0, 0, 0, 0, 1'b1);
            end else begin
               for (k = 0; k < tbl_count; k++) begin
                  expect_rsp(ST_READ, tbl_x[k], tbl_y[k], tbl_w[k], tbl_h[k],
                             k + 1 == tbl_count);
               end
            end
         end
         default: begin
            // unused code: no response
         end
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Response checker
   // --------------------------------------------------------------------------
   function automatic void check_response(rsp_type got);
      rsp_type want;
      bit      bad;
      if (expected_rsps.size() == 0) begin
         if (mismatch_count < 10) begin
            $display("unexpected response: st=%0d x=%0d y=%0d w=%0d h=%0d last=%0b ovf=%0b",
                     got.status, got.out_x, got.out_y, got.out_w, got.out_h, got.last,
                     got.overflowed);
         end
         mismatch_count++;
         return;
      end
      want = expected_rsps.pop_front();
      bad = (got.status !== want.status) || (got.out_x !== want.out_x) ||
            (got.out_y !== want.out_y) || (got.out_w !== want.out_w) ||
            (got.out_h !== want.out_h) || (got.last !== want.last) ||
            (got.overflowed !== want.overflowed);
      if (bad) begin
         if (mismatch_count < 10) begin
            $display("response mismatch at %0t", $realtime);
            $display("  exp st=%0d x=%0d y=%0d w=%0d h=%0d last=%0b ovf=%0b",
                     want.status, want.out_x, want.out_y, want.out_w, want.out_h,
                     want.last, want.overflowed);
            $display("  got st=%0d x=%0d y=%0d w=%0d h=%0d last=%0b ovf=%0b",
                     got.status, got.out_x, got.out_y, got.out_w, got.out_h,
                     got.last, got.overflowed);
         end
         mismatch_count++;
      end
   endfunction

   // Mostly short gaps, a few long ones; none while steady or under the hold-off
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || hold_active) return 0;
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // --------------------------------------------------------------------------
   // Request driver: offer queued requests, predict on acceptance
   // --------------------------------------------------------------------------
   int req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || !req_stall) begin
         // a request held high without stall was taken at this edge
         if (req_valid) begin
            predict_request(req_data);
            req_gap = pick_gap();
         end
         if (req_gap == 0 && pending_reqs.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
            if (req_gap != 0) req_gap--;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Response monitor: check accepted responses, stall at random
   // --------------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_response(rsp_data);
         if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
         if (hold_active) begin
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   function automatic void queue_req(logic [CMD_W-1:0] cmd, int l, int t, int r, int b);
      req_type q;
      q.command     = cmd;
      q.rect_left   = EDGE_W'(l);
      q.rect_top    = EDGE_W'(t);
      q.rect_right  = EDGE_W'(r);
      q.rect_bottom = EDGE_W'(b);
      pending_reqs = {pending_reqs, q};
   endfunction

   // Clear, then lay out 17 cells at least one pixel apart so that the table runs full
   function automatic void queue_grid();
      int cw, ch, l, t;
      cw = scr_width / 5 - 1;
      ch = scr_height / 4 - 1;
      if (cw < 1) cw = 1;
      if (ch < 1) ch = 1;
      queue_req(CMD_CLEAR, 0, 0, 0, 0);
      for (int n = 0; n < TBL_DEPTH + 1; n++) begin
         l = (n % 5) * (cw + 1);
         t = (n / 5) * (ch + 1);
         queue_req(CMD_ADD, l, t, l + $urandom_range(1, cw), t + $urandom_range(1, ch));
      end
   endfunction

   function automatic void queue_random(int count);
      int sent, roll, l, t;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            // clustered add around the screen, edges spilling a little over
            l = int'($urandom_range(0, scr_width + 8)) - 4;
            t = int'($urandom_range(0, scr_height + 8)) - 4;
            queue_req(CMD_ADD, l, t, l + $urandom_range(0, scr_width / 3 + 2),
                      t + $urandom_range(0, scr_height / 3 + 2));
            sent++;
         end else if (roll < 68) begin
            // full 16-bit edges
            queue_req(CMD_ADD, $urandom, $urandom, $urandom, $urandom);
            sent++;
         end else if (roll < 83) begin
            queue_req(CMD_READ, $urandom, $urandom, $urandom, $urandom);
            sent++;
         end else if (roll < 90) begin
            queue_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
            sent++;
         end else if (roll < 97) begin
            // ignored by the block, so not counted
            queue_req(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
         end else begin
            queue_grid();
            queue_req(CMD_READ, 0, 0, 0, 0);
            sent += TBL_DEPTH + 3;
         end
      end
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == REG_SCREEN_WIDTH) scr_width = val;
      else scr_height = val;
   endtask

   // Wait until every request went out and every response came back, then
   // give an ignored request time to leave the block
   task automatic settle();
      int waited;
      waited = 0;
      while ((pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) &&
             waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int w, int h, int count);
      write_csr(REG_SCREEN_WIDTH, CSR_W'(w));
      write_csr(REG_SCREEN_HEIGHT, CSR_W'(h));
      queue_random(count);
      settle();
   endtask

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset screen size of 640x480
      queue_req(CMD_READ, 0, 0, 0, 0);                       // read of an empty table
      queue_req(CMD_ADD, -32768, -32768, 32767, 32767);      // clamps to the whole screen
      queue_req(CMD_READ, 0, 0, 0, 0);
      queue_req(CMD_CLEAR, 0, 0, 0, 0);
      queue_req(CMD_ADD, 100, 10, 100, 50);                  // zero width
      queue_req(CMD_ADD, 10, 50, 20, 50);                    // zero height
      queue_req(CMD_ADD, -20, -20, -1, -1);                  // left of and above the screen
      queue_req(CMD_ADD, 700, 500, 900, 600);                // beyond the screen
      queue_req(CMD_ADD, 0, 0, 10, 10);
      queue_req(CMD_ADD, 10, 0, 20, 10);                     // shares an edge: merges
      queue_req(CMD_ADD, 21, 0, 30, 10);                     // one pixel apart: stays
      queue_req(CMD_ADD, 30, 10, 40, 20);                    // touches at a corner: merges
      queue_req(CMD_ADD, 0, 100, 10, 110);
      queue_req(CMD_ADD, 20, 100, 30, 110);
      queue_req(CMD_ADD, 5, 100, 25, 110);                   // bridges two, rescans
      queue_req(CMD_UNUSED, 1, 2, 3, 4);
      queue_req(CMD_READ, 0, 0, 0, 0);
      queue_grid();                                          // last cell finds the table full
      queue_req(CMD_READ, 0, 0, 0, 0);                       // a full read-out
      queue_req(CMD_ADD, 0, 0, 700, 5);                      // merges a row while flagged
      queue_req(CMD_CLEAR, 0, 0, 0, 0);                      // drops the overflow flag
      settle();

      // A 4096x4096 screen, then tiny and degenerate ones
      run_phase(4096, 4096, 40);
      run_phase(1, 1, 20);
      run_phase(COORD_MAX, 0, 15);
      run_phase(0, COORD_MAX, 15);

      // Long response hold-off while the sender keeps offering requests
      write_csr(REG_SCREEN_WIDTH, CSR_W'($urandom_range(1, 4096)));
      write_csr(REG_SCREEN_HEIGHT, CSR_W'($urandom_range(1, 4096)));
      queue_random(40);
      @(posedge clock);
      hold_armed <= 1'b1;
      settle();

      // Back to the reset size without any idling
      @(posedge clock);
      steady <= 1'b1;
      run_phase(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, 40);
      @(posedge clock);
      steady <= 1'b0;

      // anything still expected now never arrived
      mismatch_count += expected_rsps.size();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Hard stop well past the slowest correct run
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
src/drc_pkg.sv
src/drc_ram.sv
src/dirty_rect_coalescer.sv
tb/tb_dirty_rect_coalescer.sv
